/* sv/time_offset_median_filter_core_assert.svh */
// Assertion macros shared by the time offset median filter modules.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TIME_OFFSET_MEDIAN_FILTER_CORE_ASSERT_SVH
`define TIME_OFFSET_MEDIAN_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define TOMF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TOMF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/tomf_pkg.sv */
// Package for the time offset median filter: sizes, constants, status codes
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package tomf_pkg;

	// Window of newest samples and the widths that follow from it
	localparam int WINDOW_DEPTH = 8;
	localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int COUNT_OUT_W  = 4;

	// Seconds between the NTP era start and the Unix epoch
	localparam logic [31:0] EPOCH_DIFF        = 32'h83AA7E80;
	localparam logic [7:0]  MAX_STRATUM_RESET = 8'd14;
	localparam logic [1:0]  LEAP_ALARM        = 2'b11;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_ALARM   = 2'd1,
		STATUS_STRATUM = 2'd2
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic eval;
		logic rank_step;
		logic mean;
		logic load_out;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic accept_ok;
		logic rank_last;
	} dp_stat_t;

endpackage

`default_nettype wire

/* sv/tomf_reply_if.sv */
// Request channel carrying one time-server reply.
// Stand-alone; field widths are fixed by the reply format.
`default_nettype none

interface tomf_reply_if;
	logic        valid;
	logic        ready;
	logic [31:0] header_word;
	logic [31:0] receive_seconds;
	logic [31:0] local_seconds;

	modport source (output valid, output header_word, output receive_seconds,
		output local_seconds, input ready);
	modport sink (input valid, input header_word, input receive_seconds,
		input local_seconds, output ready);
endinterface

`default_nettype wire

/* sv/tomf_result_if.sv */
// Request channel carrying one filter result per reply.
// Stand-alone; field widths are fixed by the result format.
`default_nettype none

interface tomf_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] sample_offset;
	logic signed [31:0] system_offset;
	logic [3:0]         sample_count;

	modport source (output valid, output status, output sample_offset,
		output system_offset, output sample_count, input ready);
	modport sink (input valid, input status, input sample_offset,
		input system_offset, input sample_count, output ready);
endinterface

`default_nettype wire

/* sv/tomf_ctrl.sv */
// Controller for the time offset median filter: sequences check, rank pass,
// mean and result load. Uses tomf_pkg and the assertion macro header.
`default_nettype none
`include "time_offset_median_filter_core_assert.svh"

module tomf_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 reply_valid,
	output      logic                 reply_ready,
	output      logic                 result_valid,
	input  wire logic                 result_ready,
	input  wire tomf_pkg::dp_stat_t   stat,
	output      tomf_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RANK,
		ST_MEAN,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   load_ok;

	// Output register is free when empty or being drained this cycle
	assign load_ok      = !result_valid_q || result_ready;
	assign reply_ready  = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == ST_IDLE) && reply_valid;
		cmd.eval      = (state_q == ST_EVAL);
		cmd.rank_step = (state_q == ST_RANK);
		cmd.mean      = (state_q == ST_MEAN);
		cmd.load_out  = (state_q == ST_LOAD) && load_ok;
	end

	// Advance state and hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (reply_valid) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= stat.accept_ok ? ST_RANK : ST_LOAD;
				end
				ST_RANK: begin
					if (stat.rank_last) state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (load_ok) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TOMF_ASSERT_NXT(a_accept_eval, reply_valid && reply_ready, state_q == ST_EVAL, "accepted request did not start evaluation")
	`TOMF_ASSERT_NXT(a_reject_skip, (state_q == ST_EVAL) && !stat.accept_ok, state_q == ST_LOAD, "rejected reply entered rank pass")
	`TOMF_ASSERT_NXT(a_load_waits, (state_q == ST_LOAD) && result_valid_q && !result_ready, (state_q == ST_LOAD) && result_valid_q, "result overwritten while stalled")

endmodule

`default_nettype wire

/* sv/tomf_dp.sv */
// Datapath for the time offset median filter: reply check, sample window,
// rank pass, median mean and result register. Uses tomf_pkg and assertion macros.
`default_nettype none
`include "time_offset_median_filter_core_assert.svh"

module tomf_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [7:0]           cfg_wdata,
	input  wire logic [31:0]          header_word,
	input  wire logic [31:0]          receive_seconds,
	input  wire logic [31:0]          local_seconds,
	input  wire tomf_pkg::ctrl_cmd_t  cmd,
	output      tomf_pkg::dp_stat_t   stat,
	output      logic [1:0]           status,
	output      logic signed [31:0]   sample_offset,
	output      logic signed [31:0]   system_offset,
	output      logic [3:0]           sample_count
);

	localparam int Depth = tomf_pkg::WINDOW_DEPTH;
	localparam int IdxW  = tomf_pkg::IDX_W;
	localparam int CntW  = tomf_pkg::CNT_W;
	localparam int OutW  = tomf_pkg::COUNT_OUT_W;

	logic [7:0]          max_stratum_q;
	logic [31:0]         header_q;
	logic [31:0]         recv_q;
	logic [31:0]         local_q;
	tomf_pkg::status_t   status_q;
	logic signed [31:0]  sample_q;
	logic signed [31:0]  window_q [Depth];
	logic [CntW-1:0]     held_q;
	logic [IdxW-1:0]     oldest_q;
	logic signed [31:0]  median_q;
	logic [IdxW-1:0]     idx_q;
	logic signed [31:0]  hi_q;
	logic signed [31:0]  lo_q;
	logic [1:0]          out_status_q;
	logic signed [31:0]  out_sample_q;
	logic signed [31:0]  out_median_q;
	logic [OutW-1:0]     out_count_q;

	logic                alarm;
	logic                bad_stratum;
	logic [7:0]          stratum;
	logic signed [31:0]  offset_w;
	logic signed [31:0]  cur_w;
	logic [CntW-1:0]     rank_w;
	logic [CntW-1:0]     half_w;
	logic signed [32:0]  sum_w;
	logic signed [32:0]  adj_w;
	logic signed [31:0]  mid_w;
	logic signed [31:0]  med_w;

	// Check the captured reply and form its offset
	assign stratum     = header_q[23:16];
	assign alarm       = (header_q[31:30] == tomf_pkg::LEAP_ALARM);
	assign bad_stratum = (stratum == 8'd0) || (stratum > max_stratum_q);
	assign offset_w    = recv_q - local_q - tomf_pkg::EPOCH_DIFF;

	assign stat.accept_ok = !alarm && !bad_stratum;
	assign stat.rank_last = ((CntW'(idx_q) + CntW'(1)) == held_q);

	// Rank of the current slot among held samples; ties broken by slot index
	always_comb begin
		cur_w  = window_q[idx_q];
		rank_w = '0;
		for (int j = 0; j < Depth; j++) begin
			if (CntW'(j) < held_q) begin
				if ((window_q[j] < cur_w) || ((window_q[j] == cur_w) && (IdxW'(j) < idx_q))) begin
					rank_w = rank_w + CntW'(1);
				end
			end
		end
	end

	assign half_w = held_q >> 1;

	// Middle sample, or mean of two middle ones rounded toward zero; +/-1 becomes 0
	always_comb begin
		sum_w = {hi_q[31], hi_q} + {lo_q[31], lo_q};
		adj_w = sum_w + {32'd0, sum_w[32]};
		mid_w = held_q[0] ? hi_q : adj_w[32:1];
		med_w = ((mid_w == 32'sd1) || (mid_w == -32'sd1)) ? 32'sd0 : mid_w;
	end

	// Hold the stratum limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_stratum_q <= tomf_pkg::MAX_STRATUM_RESET;
		end else if (cfg_we) begin
			max_stratum_q <= cfg_wdata;
		end
	end

	// Control state of the window and the median
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			oldest_q <= '0;
			median_q <= '0;
		end else begin
			if (cmd.eval && stat.accept_ok) begin
				if (held_q < CntW'(Depth)) begin
					held_q <= held_q + CntW'(1);
				end else begin
					oldest_q <= (oldest_q == IdxW'(Depth - 1)) ? '0 : oldest_q + IdxW'(1);
				end
			end
			if (cmd.mean) begin
				median_q <= med_w;
			end
		end
	end

	// Capture the request, write the window, run the rank pass, load the result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			header_q <= header_word;
			recv_q   <= receive_seconds;
			local_q  <= local_seconds;
		end
		if (cmd.eval) begin
			idx_q <= '0;
			if (alarm) begin
				status_q <= tomf_pkg::STATUS_ALARM;
				sample_q <= '0;
			end else if (bad_stratum) begin
				status_q <= tomf_pkg::STATUS_STRATUM;
				sample_q <= '0;
			end else begin
				status_q <= tomf_pkg::STATUS_OK;
				sample_q <= offset_w;
				if (held_q < CntW'(Depth)) begin
					window_q[held_q[IdxW-1:0]] <= offset_w;
				end else begin
					window_q[oldest_q] <= offset_w;
				end
			end
		end
		if (cmd.rank_step) begin
			idx_q <= idx_q + IdxW'(1);
			if (rank_w == half_w) begin
				hi_q <= cur_w;
			end
			if ((rank_w + CntW'(1)) == half_w) begin
				lo_q <= cur_w;
			end
		end
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_sample_q <= sample_q;
			out_median_q <= median_q;
			out_count_q  <= OutW'(held_q);
		end
	end

	assign status        = out_status_q;
	assign sample_offset = out_sample_q;
	assign system_offset = out_median_q;
	assign sample_count  = out_count_q;

	`TOMF_ASSERT_IMP(a_held_bound, 1'b1, held_q <= CntW'(Depth), "sample count beyond window depth")
	`TOMF_ASSERT_NXT(a_reject_stable, cmd.eval && !stat.accept_ok, $stable(held_q) && $stable(oldest_q), "rejected reply changed window state")
	`TOMF_ASSERT_IMP(a_oldest_idle, held_q < CntW'(Depth), oldest_q == '0, "oldest slot moved before window filled")

endmodule

`default_nettype wire

/* sv/time_offset_median_filter_core.sv */
// Each accepted reply is checked and, if it passes, goes through the rank pass, the mean
// and the result load; a rejected reply skips the rank pass and mean and goes to the load.
// A new reply is taken only after the last result is loaded into the result register,
// and the rank pass ranks one window slot per cycle against all held samples.
// Reset (arst_n low, asynchronous): window empty, median 0, stratum limit 14,
// no result pending; window contents are not cleared.
`default_nettype none

module time_offset_median_filter_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	tomf_reply_if.sink       reply,
	tomf_result_if.source    result
);

	tomf_pkg::ctrl_cmd_t cmd;
	tomf_pkg::dp_stat_t  stat;

	// Sequence each request through check, rank pass, mean and result load
	tomf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.reply_valid  (reply.valid),
		.reply_ready  (reply.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	// Window storage, ranking and the result register
	tomf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.header_word     (reply.header_word),
		.receive_seconds (reply.receive_seconds),
		.local_seconds   (reply.local_seconds),
		.cmd             (cmd),
		.stat            (stat),
		.status          (result.status),
		.sample_offset   (result.sample_offset),
		.system_offset   (result.system_offset),
		.sample_count    (result.sample_count)
	);

endmodule

`default_nettype wire
